>>> design/mrlm_pkg.sv
// types, codes and helpers shared by the line matcher
// no dependencies; compile first
package mrlm_pkg;

  localparam int ELEM_SLOTS = 16;  // fixed by the width of the pattern registers

  typedef enum logic [1:0] {
    ACT_TEXT     = 2'd0,
    ACT_EOL      = 2'd1,
    ACT_NEW_FILE = 2'd2,
    ACT_UNUSED   = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    REG_CHARS_LOW  = 4'd0,
    REG_CHARS_HIGH = 4'd1,
    REG_KINDS      = 4'd2,
    REG_LENGTH     = 4'd3,
    REG_ANCHOR_BEG = 4'd4,
    REG_ANCHOR_END = 4'd5,
    REG_FOLD_CASE  = 4'd6,
    REG_INVERT     = 4'd7
  } reg_index_t;

  // compiled pattern as seen by the automaton
  typedef struct packed {
    logic [ELEM_SLOTS-1:0][7:0] chars;
    logic [ELEM_SLOTS-1:0][1:0] kinds;  // bit 0: any char, bit 1: repeated
    logic                       fold_case;
  } pattern_t;

  function automatic logic [7:0] fold(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && c >= 8'h41 && c <= 8'h5a)
      r = c + 8'h20;
    return r;
  endfunction

endpackage

>>> design/mrlm_chan_if.sv
// valid/ready channel interfaces for text input, line results and register writes
// depends on mrlm_pkg
interface mrlm_text_if;
  logic                valid;
  logic                ready;
  mrlm_pkg::action_t   action;
  logic [7:0]          character;
  modport source (output valid, output action, output character, input ready);
  modport sink   (input valid, input action, input character, output ready);
endinterface

interface mrlm_result_if;
  logic        valid;
  logic        ready;
  logic        line_selected;
  logic [31:0] line_number;
  logic [31:0] hit_count;
  modport source (output valid, output line_selected, output line_number,
                  output hit_count, input ready);
  modport sink   (input valid, input line_selected, input line_number,
                  input hit_count, output ready);
endinterface

interface mrlm_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/mrlm_step.sv
// one automaton step: epsilon closure over repeated elements, then advance on a byte
// depends on mrlm_pkg
module mrlm_step #(
  parameter int PATTERN_MAX = 16,
  parameter int LW          = $clog2(PATTERN_MAX + 1)
) (
  input  logic [PATTERN_MAX:0] cur_set,
  input  logic [LW-1:0]        len,
  input  mrlm_pkg::pattern_t   pattern,
  input  logic [7:0]           character,
  output logic [PATTERN_MAX:0] next_set,
  output logic                 full_match
);
  import mrlm_pkg::*;

  logic [7:0]           c_folded;
  logic [PATTERN_MAX:0] closed_set;

  assign c_folded = fold(character, pattern.fold_case);

  // closure ripples like a carry chain, one bit per element
  always_comb begin
    closed_set = '0;
    for (int j = 0; j <= PATTERN_MAX; j++) begin
      if (LW'(j) <= len)
        closed_set[j] = cur_set[j];
    end
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (LW'(i) < len && closed_set[i] && pattern.kinds[i][1])
        closed_set[i+1] = 1'b1;
    end
  end

  always_comb begin
    next_set = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (LW'(i) < len && closed_set[i] &&
          (pattern.kinds[i][0] || fold(pattern.chars[i], pattern.fold_case) == c_folded)) begin
        if (pattern.kinds[i][1])
          next_set[i] = 1'b1;
        else
          next_set[i+1] = 1'b1;
      end
    end
  end

  assign full_match = closed_set[len];

endmodule

>>> design/minimal_regex_line_matcher.sv
// line matcher top level: config registers, line state, counters, result register
// depends on mrlm_pkg, mrlm_chan_if, mrlm_step
//
//  channel   dir  transaction carries
//  text_in   in   action, character
//  result    out  line_selected, line_number, hit_count (one per end of line)
//  cfg       in   index, data (register write)
//
// one transaction per cycle unless stalled; the whole automaton step sits between the state
// registers and the result register, so throughput is one item per cycle.
// a line result appears in the cycle after the end-of-line transaction.
// rst is synchronous and clears line state, counters, pattern registers and result valid.
// text_in stalls only while a result is held and result.ready is low.
module minimal_regex_line_matcher #(
  parameter int PATTERN_MAX = 16,
  parameter int COUNT_WIDTH = 32
) (
  input logic             clk,
  input logic             rst,
  mrlm_text_if.sink       text_in,
  mrlm_result_if.source   result,
  mrlm_cfg_if.sink        cfg
);
  import mrlm_pkg::*;

  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

  logic [63:0] chars_low;
  logic [63:0] chars_high;
  logic [31:0] kinds;
  logic [4:0]  pattern_length;
  logic        anchor_start;
  logic        anchor_end;
  logic        ignore_case;
  logic        invert_match;

  logic [PATTERN_MAX:0]   active_positions;
  logic                   match_seen;
  logic                   at_line_start;
  logic                   text_ended;
  logic [COUNT_WIDTH-1:0] lines_counted;
  logic [COUNT_WIDTH-1:0] hits_counted;

  logic                   out_valid;
  logic                   out_selected;
  logic [31:0]            out_line;
  logic [31:0]            out_hits;

  pattern_t               pattern;
  logic [4:0]             len_clip;
  logic [LW-1:0]          len;
  logic [PATTERN_MAX:0]   cur_set;
  logic [PATTERN_MAX:0]   next_set;
  logic                   full_match;
  logic                   accept;
  logic                   selected;
  logic [COUNT_WIDTH-1:0] lines_next;
  logic [COUNT_WIDTH-1:0] hits_next;

  assign pattern.chars     = {chars_high, chars_low};
  assign pattern.kinds     = kinds;
  assign pattern.fold_case = ignore_case;

  assign len_clip = (pattern_length > 5'(PATTERN_MAX)) ? 5'(PATTERN_MAX) : pattern_length;
  assign len      = LW'(len_clip);

  // position zero is re-seeded every byte unless anchored at line start
  assign cur_set = active_positions |
                   {{PATTERN_MAX{1'b0}}, (!anchor_start || at_line_start)};

  mrlm_step #(.PATTERN_MAX(PATTERN_MAX), .LW(LW)) u_step (
    .cur_set    (cur_set),
    .len        (len),
    .pattern    (pattern),
    .character  (text_in.character),
    .next_set   (next_set),
    .full_match (full_match)
  );

  assign text_in.ready = !out_valid || result.ready;
  assign accept        = text_in.valid && text_in.ready;
  assign cfg.ready     = 1'b1;

  assign selected   = (match_seen || full_match) != invert_match;
  assign lines_next = (lines_counted == CMAX) ? lines_counted : lines_counted + 1'b1;
  assign hits_next  = (selected && hits_counted != CMAX) ? hits_counted + 1'b1 : hits_counted;

  always_ff @(posedge clk) begin
    if (rst) begin
      chars_low      <= '0;
      chars_high     <= '0;
      kinds          <= '0;
      pattern_length <= '0;
      anchor_start   <= 1'b0;
      anchor_end     <= 1'b0;
      ignore_case    <= 1'b0;
      invert_match   <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_CHARS_LOW:  chars_low      <= cfg.data;
        REG_CHARS_HIGH: chars_high     <= cfg.data;
        REG_KINDS:      kinds          <= cfg.data[31:0];
        REG_LENGTH:     pattern_length <= cfg.data[4:0];
        REG_ANCHOR_BEG: anchor_start   <= cfg.data[0];
        REG_ANCHOR_END: anchor_end     <= cfg.data[0];
        REG_FOLD_CASE:  ignore_case    <= cfg.data[0];
        REG_INVERT:     invert_match   <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_positions <= {{PATTERN_MAX{1'b0}}, 1'b1};
      match_seen       <= 1'b0;
      at_line_start    <= 1'b1;
      text_ended       <= 1'b0;
      lines_counted    <= '0;
      hits_counted     <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (result.ready && !(accept && text_in.action == ACT_EOL))
        out_valid <= 1'b0;
      if (accept) begin
        case (text_in.action)
          ACT_TEXT: begin
            if (!text_ended) begin
              if (text_in.character == 8'h00) begin
                text_ended <= 1'b1;
              end else begin
                if (!anchor_end && full_match)
                  match_seen <= 1'b1;
                active_positions <= next_set;
                at_line_start    <= 1'b0;
              end
            end
          end
          ACT_EOL: begin
            lines_counted    <= lines_next;
            hits_counted     <= hits_next;
            out_valid        <= 1'b1;
            out_selected     <= selected;
            out_line         <= 32'(lines_next);
            out_hits         <= 32'(hits_next);
            active_positions <= {{PATTERN_MAX{1'b0}}, 1'b1};
            match_seen       <= 1'b0;
            at_line_start    <= 1'b1;
            text_ended       <= 1'b0;
          end
          ACT_NEW_FILE: begin
            lines_counted    <= '0;
            hits_counted     <= '0;
            active_positions <= {{PATTERN_MAX{1'b0}}, 1'b1};
            match_seen       <= 1'b0;
            at_line_start    <= 1'b1;
            text_ended       <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  assign result.valid         = out_valid;
  assign result.line_selected = out_selected;
  assign result.line_number   = out_line;
  assign result.hit_count     = out_hits;

  a_eol_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && text_in.action == ACT_EOL |=> out_valid)
    else $error("end of line gave no result");

  a_hits_bounded: assert property (@(posedge clk) disable iff (rst)
    hits_counted <= lines_counted)
    else $error("hit count above line count");

  a_new_file_clears: assert property (@(posedge clk) disable iff (rst)
    accept && text_in.action == ACT_NEW_FILE |=> lines_counted == '0 && hits_counted == '0)
    else $error("new file left counters set");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !text_in.ready |-> out_valid)
    else $error("input stalled with empty result register");

  a_ended_line_frozen: assert property (@(posedge clk) disable iff (rst)
    text_ended && accept && text_in.action == ACT_TEXT |=> $stable(active_positions))
    else $error("automaton moved after end of text");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for minimal_regex_line_matcher: directed and random lines
// depends on mrlm_pkg, mrlm_chan_if and the matcher rtl
module tb;
  import mrlm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASES = 12;
  localparam int unsigned ITEMS_PER_PHASE = 118;

  typedef struct packed {
    logic        selected;
    logic [31:0] number;
    logic [31:0] hits;
  } line_result_t;

  class line_scoreboard;
    logic [63:0]  chars_lo, chars_hi;
    logic [31:0]  kinds;
    logic [4:0]   plen;
    bit           anchor_beg, anchor_end, fold_case, invert;
    logic [16:0]  live;
    bit           seen, line_start, text_done;
    logic [31:0]  lines, hits;
    line_result_t expected_lines[$];
    int           mismatches;

    function new();
      chars_lo = '0;
      chars_hi = '0;
      kinds = '0;
      plen = '0;
      anchor_beg = 0;
      anchor_end = 0;
      fold_case = 0;
      invert = 0;
      lines = '0;
      hits = '0;
      mismatches = 0;
      clear_line();
    endfunction

    function void clear_line();
      live = 17'h1;
      seen = 0;
      line_start = 1;
      text_done = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [63:0] d);
      case (idx)
        REG_CHARS_LOW:  chars_lo = d;
        REG_CHARS_HIGH: chars_hi = d;
        REG_KINDS:      kinds = d[31:0];
        REG_LENGTH:     plen = d[4:0];
        REG_ANCHOR_BEG: anchor_beg = d[0];
        REG_ANCHOR_END: anchor_end = d[0];
        REG_FOLD_CASE:  fold_case = d[0];
        REG_INVERT:     invert = d[0];
        default: ;
      endcase
    endfunction

    function int unsigned used_len();
      return (plen > 5'd16) ? 16 : int'(plen);
    endfunction

    function logic [1:0] kind_of(int unsigned i);
      return kinds[2*i +: 2];
    endfunction

    function logic [7:0] char_of(int unsigned i);
      return (i < 8) ? chars_lo[8*i +: 8] : chars_hi[8*(i-8) +: 8];
    endfunction

    function logic [7:0] lower(logic [7:0] c);
      if (fold_case && c >= 8'h41 && c <= 8'h5a) return c + 8'h20;
      return c;
    endfunction

    // repeated elements may be skipped, so their successor is live too
    function logic [16:0] closure(logic [16:0] s, int unsigned len);
      logic [31:0] m;
      logic [16:0] r;
      logic [1:0]  k;
      m = (32'd1 << (len + 1)) - 32'd1;
      r = s & m[16:0];
      for (int unsigned i = 0; i < len; i++) begin
        k = kind_of(i);
        if (r[i] && k[1]) r[i+1] = 1'b1;
      end
      return r;
    endfunction

    function logic [16:0] step_set(logic [16:0] s, int unsigned len, logic [7:0] c);
      logic [16:0] n;
      logic [1:0]  k;
      n = '0;
      for (int unsigned i = 0; i < len; i++) begin
        k = kind_of(i);
        if (s[i] && (k[0] || lower(char_of(i)) == lower(c))) begin
          if (k[1]) n[i] = 1'b1;
          else n[i+1] = 1'b1;
        end
      end
      return n;
    endfunction

    function logic [16:0] start_set(int unsigned len);
      logic [16:0] s;
      s = live;
      if (!anchor_beg || line_start) s[0] = 1'b1;
      return closure(s, len);
    endfunction

    function void note_item(action_t act, logic [7:0] c);
      int unsigned  len;
      logic [16:0]  s;
      bit           sel;
      line_result_t r;
      len = used_len();
      case (act)
        ACT_TEXT: begin
          if (!text_done) begin
            if (c == 8'h00) begin
              text_done = 1;
            end else begin
              s = start_set(len);
              if (!anchor_end && s[len]) seen = 1;
              live = step_set(s, len, c);
              line_start = 0;
            end
          end
        end
        ACT_EOL: begin
          s = start_set(len);
          sel = (seen || s[len]) != invert;
          if (lines != '1) lines++;
          if (sel && hits != '1) hits++;
          r = '{sel, lines, hits};
          expected_lines.push_back(r);
          clear_line();
        end
        ACT_NEW_FILE: begin
          clear_line();
          lines = '0;
          hits = '0;
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic sel, logic [31:0] num, logic [31:0] h);
      line_result_t e;
      if (expected_lines.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected line result: sel %0b line %0d hits %0d", sel, num, h);
        return;
      end
      e = expected_lines.pop_front();
      if (sel !== e.selected || num !== e.number || h !== e.hits) begin
        mismatches++;
        if (mismatches <= 10)
          $display("line result mismatch: expected sel %0b line %0d hits %0d, got sel %0b line %0d hits %0d",
                   e.selected, e.number, e.hits, sel, num, h);
      end
    endfunction

    function int outstanding();
      return expected_lines.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic rx_ready = 1'b0;
  int unsigned cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int unsigned items_sent = 0;
  line_scoreboard sb;

  mrlm_text_if   text_ch();
  mrlm_result_if res_ch();
  mrlm_cfg_if    cfg_ch();

  assign res_ch.ready = rx_ready;

  minimal_regex_line_matcher dut (
    .clk     (clk),
    .rst     (rst),
    .text_in (text_ch),
    .result  (res_ch),
    .cfg     (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    rx_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && rx_ready)
      sb.check_result(res_ch.line_selected, res_ch.line_number, res_ch.hit_count);
  end

  function automatic logic [7:0] text_char();
    string alpha;
    alpha = "abcABC.z";
    return alpha[$urandom_range(alpha.len() - 1)];
  endfunction

  // sometimes sets bits above the register's width, which it must drop
  function automatic logic [63:0] with_noise(logic [63:0] v, int unsigned bits);
    if ($urandom_range(3) == 0) return v | ({$urandom, $urandom} << bits);
    return v;
  endfunction

  task automatic send_item(action_t act, logic [7:0] c);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      text_ch.valid <= 1'b0;
      @(negedge clk);
    end
    text_ch.valid <= 1'b1;
    text_ch.action <= act;
    text_ch.character <= c;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    sb.note_item(act, c);
    if (act != ACT_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [63:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.write_reg(idx, d);
    @(negedge clk);
  endtask

  // sender stops until every line result is back, then gives the pipe time to settle
  task automatic quiesce();
    text_ch.valid <= 1'b0;
    do @(negedge clk); while (sb.outstanding() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic configure(logic [63:0] lo, logic [63:0] hi, logic [63:0] kinds,
                           logic [63:0] len_word, logic [63:0] beg, logic [63:0] end_w,
                           logic [63:0] fold_w, logic [63:0] inv);
    write_reg(REG_CHARS_LOW, lo);
    write_reg(REG_CHARS_HIGH, hi);
    write_reg(REG_KINDS, kinds);
    write_reg(REG_LENGTH, len_word);
    write_reg(REG_ANCHOR_BEG, beg);
    write_reg(REG_ANCHOR_END, end_w);
    write_reg(REG_FOLD_CASE, fold_w);
    write_reg(REG_INVERT, inv);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_config();
    logic [63:0] lo, hi;
    int unsigned len, r;
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    r = $urandom_range(99);
    if (r < 10) len = 0;
    else if (r < 20) len = 16;
    else if (r < 28) len = $urandom_range(31, 17);
    else len = $urandom_range(5, 1);
    // pattern bytes mostly from the text alphabet so lines can hit
    for (int unsigned i = 0; i < 16 && i < len; i++) begin
      if ($urandom_range(7) != 0) begin
        if (i < 8) lo[8*i +: 8] = text_char();
        else hi[8*(i-8) +: 8] = text_char();
      end
    end
    configure(lo, hi, with_noise(64'($urandom), 32), with_noise(64'(len), 5),
              with_noise(64'($urandom_range(1)), 1), with_noise(64'($urandom_range(1)), 1),
              with_noise(64'($urandom_range(1)), 1), with_noise(64'($urandom_range(1)), 1));
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(ACT_TEXT, s[i]);
  endtask

  task automatic send_line();
    logic [7:0]  txt[$];
    logic [7:0]  ch;
    logic [1:0]  k;
    int unsigned r, reps;
    r = $urandom_range(99);
    if (r < 60) begin
      // text built to follow the pattern, then perhaps spoilt
      if (!sb.anchor_beg || $urandom_range(3) == 0)
        repeat ($urandom_range(3)) txt.push_back(text_char());
      for (int unsigned i = 0; i < sb.used_len(); i++) begin
        k = sb.kind_of(i);
        ch = sb.char_of(i);
        reps = k[1] ? $urandom_range(2) : 1;
        repeat (reps) begin
          if (k[0]) txt.push_back(text_char());
          else if ((ch | 8'h20) >= 8'h61 && (ch | 8'h20) <= 8'h7a && $urandom_range(3) == 0)
            txt.push_back(ch ^ 8'h20);
          else txt.push_back(ch);
        end
      end
      if (txt.size() != 0 && $urandom_range(4) == 0)
        txt[$urandom_range(txt.size() - 1)] = text_char();
      if (!sb.anchor_end || $urandom_range(3) == 0)
        repeat ($urandom_range(2)) txt.push_back(text_char());
    end else if (r < 90) begin
      repeat ($urandom_range(10)) txt.push_back(text_char());
    end else begin
      repeat ($urandom_range(10)) txt.push_back(8'($urandom_range(255)));
    end
    if (txt.size() != 0 && $urandom_range(19) == 0)
      txt.insert($urandom_range(txt.size() - 1), 8'h00);
    foreach (txt[j]) send_item(ACT_TEXT, txt[j]);
    send_item(ACT_EOL, 8'($urandom));
  endtask

  initial begin
    int unsigned target, r, mode;
    bit paused;
    sb = new();
    rst = 1'b1;
    text_ch.valid = 1'b0;
    text_ch.action = ACT_TEXT;
    text_ch.character = 8'h00;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_CHARS_LOW;
    cfg_ch.data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty pattern after reset matches everything, even an empty line
    send_item(ACT_EOL, 8'hff);
    send_item(ACT_TEXT, 8'hff);
    send_item(ACT_TEXT, 8'h00);
    send_item(ACT_TEXT, 8'h41);
    send_item(ACT_EOL, 8'h00);
    send_item(ACT_UNUSED, 8'h5a);
    quiesce();

    // ^H.*z$ with case folding
    configure({40'h0, 8'h7a, 8'h2e, 8'h48}, '1, 64'h0000_000c, 64'd3, 64'd1, 64'd1,
              64'd1, 64'd0);
    send_text("hxyz");
    send_item(ACT_EOL, 8'h00);
    send_text("ahz");
    send_item(ACT_EOL, 8'h00);
    // zero byte ends the text, the trailing q must not count
    send_text("hz");
    send_item(ACT_TEXT, 8'h00);
    send_text("q");
    send_item(ACT_EOL, 8'h00);
    send_text("h");
    send_item(ACT_TEXT, 8'hff);
    send_text("z");
    send_item(ACT_EOL, 8'h00);
    send_item(ACT_NEW_FILE, 8'hff);
    send_text("HZ");
    send_item(ACT_EOL, 8'hff);

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      quiesce();
      if (phase == 2) configure('1, '1, '1, 64'd31, 64'd1, 64'd1, 64'd1, 64'd1);
      else if (phase == 5) configure('0, '0, '0, '0, '0, '0, '0, '0);
      else random_config();
      mode = phase % 4;
      send_idle_pct = (mode == 1) ? 50 : (mode == 3) ? 29 : 0;
      recv_stall_pct = (mode == 2) ? 50 : (mode == 3) ? 29 : 0;
      target = items_sent + ITEMS_PER_PHASE;
      paused = 0;
      while (items_sent < target) begin
        if (!paused && items_sent + ITEMS_PER_PHASE / 2 >= target) begin
          paused = 1;
          quiesce();
        end
        r = $urandom_range(99);
        if (r < 3) send_item(ACT_NEW_FILE, 8'($urandom));
        else if (r < 5) send_item(ACT_UNUSED, 8'($urandom));
        else if (r < 8) send_item(ACT_TEXT, text_char());
        else send_line();
      end
    end

    quiesce();
    repeat (4) @(negedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> minimal_regex_line_matcher.f
design/mrlm_pkg.sv
design/mrlm_chan_if.sv
design/mrlm_step.sv
design/minimal_regex_line_matcher.sv
tb/sv/tb.sv
